>>> sv/hspf_pkg.sv
// hspf_pkg: shared types and constants for the humidity sensor pulse frame decoder
// no dependencies; used by every module of the decoder by scoped names

package hspf_pkg;

	localparam int DUR_W      = 15;
	localparam int CNT_W      = 6;
	localparam int FRAME_W    = 40;
	localparam int CFG_IDX_W  = 4;
	localparam int STATUS_W   = 2;
	localparam int WORD_W     = 16;
	localparam int BYTE_W     = 8;

	localparam logic [CNT_W-1:0] COUNT_MAX        = 6'd63;
	localparam logic [CNT_W-1:0] LAST_LEAD_SYMBOL = 6'd40;
	localparam logic [CNT_W-1:0] LAST_BIT_SYMBOL  = 6'd41;
	localparam logic [CNT_W-1:0] FIRST_BIT_SYMBOL = 6'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RESP_MIN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_MAX = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_MIN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_MAX = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX  = 4'd7;

	// register reset values
	localparam logic [DUR_W-1:0] RESP_MIN_RST = 15'd75;
	localparam logic [DUR_W-1:0] RESP_MAX_RST = 15'd85;
	localparam logic [DUR_W-1:0] LEAD_MIN_RST = 15'd48;
	localparam logic [DUR_W-1:0] LEAD_MAX_RST = 15'd55;
	localparam logic [DUR_W-1:0] ZERO_MIN_RST = 15'd22;
	localparam logic [DUR_W-1:0] ZERO_MAX_RST = 15'd30;
	localparam logic [DUR_W-1:0] ONE_MIN_RST  = 15'd68;
	localparam logic [DUR_W-1:0] ONE_MAX_RST  = 15'd75;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_START = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_BIT   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_CHECKSUM  = 2'd3;

	typedef struct packed {
		logic [DUR_W-1:0] resp_min;
		logic [DUR_W-1:0] resp_max;
		logic [DUR_W-1:0] lead_min;
		logic [DUR_W-1:0] lead_max;
		logic [DUR_W-1:0] zero_min;
		logic [DUR_W-1:0] zero_max;
		logic [DUR_W-1:0] one_min;
		logic [DUR_W-1:0] one_max;
	} cfg_t;

	typedef struct packed {
		logic pre0_ok;   // symbol 0 preamble shape
		logic pre1_ok;   // symbol 1 preamble shape
		logic zero_hit;  // high phase in bit-zero window
		logic one_hit;   // high phase in bit-one window
		logic lead_ok;   // low lead phase well formed
	} sym_class_t;

endpackage

>>> sv/hspf_cfg_regs.sv
// hspf_cfg_regs: timing window register file written through the plain write port
// depends on hspf_pkg

module hspf_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hspf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hspf_pkg::DUR_W-1:0]     cfg_data,
	output hspf_pkg::cfg_t                 cfg
);

	hspf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resp_min <= hspf_pkg::RESP_MIN_RST;
			cfg_q.resp_max <= hspf_pkg::RESP_MAX_RST;
			cfg_q.lead_min <= hspf_pkg::LEAD_MIN_RST;
			cfg_q.lead_max <= hspf_pkg::LEAD_MAX_RST;
			cfg_q.zero_min <= hspf_pkg::ZERO_MIN_RST;
			cfg_q.zero_max <= hspf_pkg::ZERO_MAX_RST;
			cfg_q.one_min  <= hspf_pkg::ONE_MIN_RST;
			cfg_q.one_max  <= hspf_pkg::ONE_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				hspf_pkg::REG_RESP_MIN: cfg_q.resp_min <= cfg_data;
				hspf_pkg::REG_RESP_MAX: cfg_q.resp_max <= cfg_data;
				hspf_pkg::REG_LEAD_MIN: cfg_q.lead_min <= cfg_data;
				hspf_pkg::REG_LEAD_MAX: cfg_q.lead_max <= cfg_data;
				hspf_pkg::REG_ZERO_MIN: cfg_q.zero_min <= cfg_data;
				hspf_pkg::REG_ZERO_MAX: cfg_q.zero_max <= cfg_data;
				hspf_pkg::REG_ONE_MIN:  cfg_q.one_min  <= cfg_data;
				hspf_pkg::REG_ONE_MAX:  cfg_q.one_max  <= cfg_data;
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/hspf_symbol_class.sv
// hspf_symbol_class: window compares that classify one pulse-pair symbol
// depends on hspf_pkg

module hspf_symbol_class (
	input  hspf_pkg::cfg_t             cfg,
	input  logic                       level_first,
	input  logic [hspf_pkg::DUR_W-1:0] duration_first,
	input  logic                       level_second,
	input  logic [hspf_pkg::DUR_W-1:0] duration_second,
	output hspf_pkg::sym_class_t       cls
);

	logic resp_first;
	logic resp_second;
	logic lead_win;

	assign resp_first  = (duration_first >= cfg.resp_min) && (duration_first <= cfg.resp_max);
	assign resp_second = (duration_second >= cfg.resp_min) && (duration_second <= cfg.resp_max);
	assign lead_win    = (duration_second >= cfg.lead_min) && (duration_second <= cfg.lead_max);

	always_comb begin
		cls.pre0_ok  = level_first && !level_second && resp_second;
		cls.pre1_ok  = level_first && resp_first;
		cls.zero_hit = (duration_first >= cfg.zero_min) && (duration_first <= cfg.zero_max);
		cls.one_hit  = (duration_first >= cfg.one_min) && (duration_first <= cfg.one_max);
		cls.lead_ok  = !level_second && lead_win;
	end

endmodule

>>> sv/hspf_frame_acc.sv
// hspf_frame_acc: capture state (count, bits, flags) and the registered result
// depends on hspf_pkg; takes the classification from hspf_symbol_class

module hspf_frame_acc #(
	parameter int FRAME_SYMBOLS = 42
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,        // symbol leaves the input stage
	input  logic                              last_symbol,
	input  hspf_pkg::sym_class_t              cls,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [hspf_pkg::STATUS_W-1:0]     status,
	output logic [hspf_pkg::WORD_W-1:0]       humidity_raw,
	output logic [hspf_pkg::WORD_W-1:0]       temperature_raw,
	output logic [hspf_pkg::BYTE_W-1:0]       checksum_received
);

	localparam logic [hspf_pkg::CNT_W-1:0] FRAME_LEN = hspf_pkg::CNT_W'(FRAME_SYMBOLS);

	logic [hspf_pkg::CNT_W-1:0]   count_q;
	logic [hspf_pkg::FRAME_W-1:0] bits_q;
	logic                         start_ok_q;
	logic                         bit_err_q;

	logic [hspf_pkg::CNT_W-1:0]   count_d;
	logic [hspf_pkg::FRAME_W-1:0] bits_d;
	logic                         start_ok_d;
	logic                         bit_err_d;
	logic                         hi_en;
	logic                         lead_en;
	logic [hspf_pkg::WORD_W-1:0]  hum;
	logic [hspf_pkg::WORD_W-1:0]  tmp;
	logic [hspf_pkg::BYTE_W-1:0]  cs;
	logic [hspf_pkg::BYTE_W-1:0]  sum;
	logic [hspf_pkg::STATUS_W-1:0] status_d;

	logic                          out_valid_q;
	logic [hspf_pkg::STATUS_W-1:0] status_q;
	logic [hspf_pkg::WORD_W-1:0]   hum_q;
	logic [hspf_pkg::WORD_W-1:0]   tmp_q;
	logic [hspf_pkg::BYTE_W-1:0]   cs_q;

	assign hi_en   = (count_q >= hspf_pkg::FIRST_BIT_SYMBOL) &&
	                 (count_q <= hspf_pkg::LAST_BIT_SYMBOL);
	assign lead_en = (count_q != '0) && (count_q <= hspf_pkg::LAST_LEAD_SYMBOL);

	always_comb begin
		if (count_q == '0) begin
			start_ok_d = cls.pre0_ok;
		end else if (count_q == hspf_pkg::CNT_W'(1)) begin
			start_ok_d = start_ok_q && cls.pre1_ok;
		end else begin
			start_ok_d = start_ok_q;
		end
		// bit zero wins where the two windows overlap; a miss shifts in a zero
		bits_d    = hi_en ? {bits_q[hspf_pkg::FRAME_W-2:0], !cls.zero_hit && cls.one_hit}
		                  : bits_q;
		bit_err_d = bit_err_q || (hi_en && !cls.zero_hit && !cls.one_hit) ||
		            (lead_en && !cls.lead_ok);
		count_d   = (count_q == hspf_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;
	end

	assign hum = bits_d[39:24];
	assign tmp = bits_d[23:8];
	assign cs  = bits_d[7:0];
	assign sum = hum[15:8] + hum[7:0] + tmp[15:8] + tmp[7:0];

	always_comb begin
		if (!start_ok_d || (count_d < FRAME_LEN)) begin
			status_d = hspf_pkg::ST_BAD_START;
		end else if (bit_err_d) begin
			status_d = hspf_pkg::ST_BAD_BIT;
		end else if (sum == cs) begin
			status_d = hspf_pkg::ST_OK;
		end else begin
			status_d = hspf_pkg::ST_CHECKSUM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			bits_q     <= '0;
			start_ok_q <= 1'b0;
			bit_err_q  <= 1'b0;
		end else if (step) begin
			if (last_symbol) begin
				count_q    <= '0;
				bits_q     <= '0;
				start_ok_q <= 1'b0;
				bit_err_q  <= 1'b0;
			end else begin
				count_q    <= count_d;
				bits_q     <= bits_d;
				start_ok_q <= start_ok_d;
				bit_err_q  <= bit_err_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_symbol) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// frames with a bad start or a bad bit report zero words; a checksum failure keeps them
	always_ff @(posedge clk) begin
		if (step && last_symbol) begin
			status_q <= status_d;
			if ((status_d == hspf_pkg::ST_BAD_START) || (status_d == hspf_pkg::ST_BAD_BIT)) begin
				hum_q <= '0;
				tmp_q <= '0;
				cs_q  <= '0;
			end else begin
				hum_q <= hum;
				tmp_q <= tmp;
				cs_q  <= cs;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign humidity_raw      = hum_q;
	assign temperature_raw   = tmp_q;
	assign checksum_received = cs_q;

endmodule

>>> sv/humidity_sensor_pulse_frame_decoder_core.sv
// humidity_sensor_pulse_frame_decoder_core: input register, symbol classifier and
// frame accumulator with a registered result, taken when the last symbol leaves the
// input register. Throughput: one symbol per cycle; a last symbol waits in the input
// register only while a previous result is still held by the output register. Reset
// (arst_n low, asynchronous) clears the capture state and both valid flags and loads
// the window registers with their defaults. Depends on hspf_pkg and submodules.

module humidity_sensor_pulse_frame_decoder_core #(
	parameter int FRAME_SYMBOLS = 42
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hspf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hspf_pkg::DUR_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              level_first,
	input  logic [hspf_pkg::DUR_W-1:0]        duration_first,
	input  logic                              level_second,
	input  logic [hspf_pkg::DUR_W-1:0]        duration_second,
	input  logic                              last_symbol,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [hspf_pkg::STATUS_W-1:0]     status,
	output logic [hspf_pkg::WORD_W-1:0]       humidity_raw,
	output logic [hspf_pkg::WORD_W-1:0]       temperature_raw,
	output logic [hspf_pkg::BYTE_W-1:0]       checksum_received
);

	hspf_pkg::cfg_t       cfg;
	hspf_pkg::sym_class_t cls;

	logic                       valid_s1;
	logic                       level_first_s1;
	logic [hspf_pkg::DUR_W-1:0] duration_first_s1;
	logic                       level_second_s1;
	logic [hspf_pkg::DUR_W-1:0] duration_second_s1;
	logic                       last_s1;
	logic                       step;
	logic                       in_xfer;

	// a last symbol needs a free result slot, any other symbol moves on at once
	assign step     = valid_s1 && (!last_s1 || !out_valid || out_ready);
	assign in_ready = !valid_s1 || step;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			level_first_s1     <= level_first;
			duration_first_s1  <= duration_first;
			level_second_s1    <= level_second;
			duration_second_s1 <= duration_second;
			last_s1            <= last_symbol;
		end
	end

	hspf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hspf_symbol_class u_class (
		.cfg             (cfg),
		.level_first     (level_first_s1),
		.duration_first  (duration_first_s1),
		.level_second    (level_second_s1),
		.duration_second (duration_second_s1),
		.cls             (cls)
	);

	hspf_frame_acc #(
		.FRAME_SYMBOLS (FRAME_SYMBOLS)
	) u_frame (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (step),
		.last_symbol       (last_s1),
		.cls               (cls),
		.out_ready         (out_ready),
		.out_valid         (out_valid),
		.status            (status),
		.humidity_raw      (humidity_raw),
		.temperature_raw   (temperature_raw),
		.checksum_received (checksum_received)
	);

endmodule

>>> sv/hspf_checker.sv
// hspf_checker: port-level assertions for the pulse frame decoder result channel
// depends on hspf_pkg; bound to humidity_sensor_pulse_frame_decoder_core below

module hspf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [hspf_pkg::STATUS_W-1:0] status,
	input logic [hspf_pkg::WORD_W-1:0]   humidity_raw,
	input logic [hspf_pkg::WORD_W-1:0]   temperature_raw,
	input logic [hspf_pkg::BYTE_W-1:0]   checksum_received
);

	logic [hspf_pkg::BYTE_W-1:0] sum;

	assign sum = humidity_raw[15:8] + humidity_raw[7:0] +
	             temperature_raw[15:8] + temperature_raw[7:0];

	// held result must not change before its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(humidity_raw) && $stable(temperature_raw) && $stable(checksum_received))
		else $error("result changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == hspf_pkg::ST_BAD_START || status == hspf_pkg::ST_BAD_BIT)
		|-> humidity_raw == '0 && temperature_raw == '0 && checksum_received == '0)
		else $error("failed frame reports nonzero words");

	a_ok_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == hspf_pkg::ST_OK |-> sum == checksum_received)
		else $error("ok status with checksum mismatch");

	a_bad_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == hspf_pkg::ST_CHECKSUM |-> sum != checksum_received)
		else $error("checksum status with matching checksum");

endmodule

bind humidity_sensor_pulse_frame_decoder_core hspf_checker u_hspf_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.status            (status),
	.humidity_raw      (humidity_raw),
	.temperature_raw   (temperature_raw),
	.checksum_received (checksum_received)
);

>>> bench/hspf_frame_check_pkg.sv
// hspf_frame_check_pkg: symbol and result types plus the frame scoreboard for the decoder bench
// the scoreboard decodes every transferred symbol on its own and checks each result against it
// depends on hspf_pkg for widths, register indexes, reset windows and status codes

package hspf_frame_check_pkg;
	import hspf_pkg::*;

	localparam int FRAME_LEN    = 42;
	localparam int REG_COUNT    = 8;
	localparam int REPORT_LIMIT = 40;

	typedef struct packed {
		logic             level_first;
		logic [DUR_W-1:0] duration_first;
		logic             level_second;
		logic [DUR_W-1:0] duration_second;
		logic             last_symbol;
	} pulse_symbol_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   humidity;
		logic [WORD_W-1:0]   temperature;
		logic [BYTE_W-1:0]   checksum;
	} frame_result_t;

	typedef logic [DUR_W-1:0] window_set_t [REG_COUNT];

	class frame_scoreboard;
		logic [DUR_W-1:0]   windows [REG_COUNT];
		logic [CNT_W-1:0]   symbol_index;
		logic [FRAME_W-1:0] frame_bits;
		bit                 preamble_ok;
		bit                 bit_error;
		frame_result_t      expected_frames [$];
		int unsigned        mismatches;

		function new();
			windows[REG_RESP_MIN] = RESP_MIN_RST;
			windows[REG_RESP_MAX] = RESP_MAX_RST;
			windows[REG_LEAD_MIN] = LEAD_MIN_RST;
			windows[REG_LEAD_MAX] = LEAD_MAX_RST;
			windows[REG_ZERO_MIN] = ZERO_MIN_RST;
			windows[REG_ZERO_MAX] = ZERO_MAX_RST;
			windows[REG_ONE_MIN]  = ONE_MIN_RST;
			windows[REG_ONE_MAX]  = ONE_MAX_RST;
			mismatches = 0;
			clear_capture();
		endfunction

		function void clear_capture();
			symbol_index = '0;
			frame_bits   = '0;
			preamble_ok  = 1'b0;
			bit_error    = 1'b0;
		endfunction

		// writes past the last window register fall on the floor
		function void write_window(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] value);
			if (idx <= REG_ONE_MAX)
				windows[idx] = value;
		endfunction

		function bit fits(logic [DUR_W-1:0] d, logic [CFG_IDX_W-1:0] lo_reg,
				logic [CFG_IDX_W-1:0] hi_reg);
			return d >= windows[lo_reg] && d <= windows[hi_reg];
		endfunction

		function int frames_due();
			return expected_frames.size();
		endfunction

		function void decode_symbol(pulse_symbol_t sym);
			frame_result_t    want;
			logic             data_bit;
			logic [BYTE_W-1:0] sum;
			if (symbol_index == 0) begin
				preamble_ok = sym.level_first && !sym.level_second &&
					fits(sym.duration_second, REG_RESP_MIN, REG_RESP_MAX);
			end else if (symbol_index == 1) begin
				preamble_ok = preamble_ok && sym.level_first &&
					fits(sym.duration_first, REG_RESP_MIN, REG_RESP_MAX);
			end
			// high phase: the zero window is tried first
			if (symbol_index >= FIRST_BIT_SYMBOL && symbol_index <= LAST_BIT_SYMBOL) begin
				data_bit = 1'b0;
				if (fits(sym.duration_first, REG_ZERO_MIN, REG_ZERO_MAX))
					data_bit = 1'b0;
				else if (fits(sym.duration_first, REG_ONE_MIN, REG_ONE_MAX))
					data_bit = 1'b1;
				else
					bit_error = 1'b1;
				frame_bits = {frame_bits[FRAME_W-2:0], data_bit};
			end
			if (symbol_index >= 1 && symbol_index <= LAST_LEAD_SYMBOL) begin
				if (sym.level_second || !fits(sym.duration_second, REG_LEAD_MIN, REG_LEAD_MAX))
					bit_error = 1'b1;
			end
			if (symbol_index != COUNT_MAX)
				symbol_index = symbol_index + 1'b1;
			if (!sym.last_symbol)
				return;

			want.humidity    = frame_bits[39:24];
			want.temperature = frame_bits[23:8];
			want.checksum    = frame_bits[7:0];
			if (!preamble_ok || symbol_index < FRAME_LEN) begin
				want.status = ST_BAD_START;
			end else if (bit_error) begin
				want.status = ST_BAD_BIT;
			end else begin
				sum = want.humidity[15:8] + want.humidity[7:0] +
					want.temperature[15:8] + want.temperature[7:0];
				want.status = (sum == want.checksum) ? ST_OK : ST_CHECKSUM;
			end
			if (want.status == ST_BAD_START || want.status == ST_BAD_BIT) begin
				want.humidity    = '0;
				want.temperature = '0;
				want.checksum    = '0;
			end
			expected_frames.push_back(want);
			clear_capture();
		endfunction

		task report_mismatch(input string what);
			if (mismatches < REPORT_LIMIT)
				$display("%0t mismatch: %s", $time, what);
			mismatches++;
		endtask

		task check_frame(input frame_result_t got);
			frame_result_t want;
			if (expected_frames.size() == 0) begin
				report_mismatch($sformatf("result with no frame pending, status %0d", got.status));
				return;
			end
			want = expected_frames.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.humidity !== want.humidity)
				report_mismatch($sformatf("humidity_raw %h, expected %h",
					got.humidity, want.humidity));
			if (got.temperature !== want.temperature)
				report_mismatch($sformatf("temperature_raw %h, expected %h",
					got.temperature, want.temperature));
			if (got.checksum !== want.checksum)
				report_mismatch($sformatf("checksum_received %h, expected %h",
					got.checksum, want.checksum));
		endtask

		task flush_leftovers();
			frame_result_t lost;
			while (expected_frames.size() != 0) begin
				lost = expected_frames.pop_front();
				report_mismatch($sformatf("result never arrived, status %0d", lost.status));
			end
		endtask
	endclass

endpackage

>>> bench/humidity_sensor_pulse_frame_decoder_core_test.sv
// humidity_sensor_pulse_frame_decoder_core_test: drives symbol captures, window settings and
// random back-pressure into the decoder and checks every frame result in order
// depends on hspf_pkg, hspf_frame_check_pkg and the decoder rtl

module humidity_sensor_pulse_frame_decoder_core_test;
	import hspf_pkg::*;
	import hspf_frame_check_pkg::*;

	localparam logic [DUR_W-1:0]     DUR_MAX        = '1;
	localparam logic [CFG_IDX_W-1:0] STRAY_INDEX_LO = REG_ONE_MAX + 1'b1;
	localparam logic [CFG_IDX_W-1:0] STRAY_INDEX_HI = '1;
	localparam int DECODE_LATENCY = 2;
	localparam int SETTLE_CYCLES  = 4 * DECODE_LATENCY;
	localparam int PHASE_ITEMS    = 108;
	localparam int PHASE_FRAMES   = 2;
	localparam int DRAIN_LIMIT    = 5000;
	localparam int LONG_FRAME_MAX = 75;

	typedef enum {
		FLAW_NONE, FLAW_CHECKSUM, FLAW_PREAMBLE, FLAW_LEAD, FLAW_HIGH, FLAW_SHORT, FLAW_LONG
	} frame_flaw_t;

	logic                 clk;
	logic                 arst_n          = 1'b0;
	logic                 cfg_we          = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index       = '0;
	logic [DUR_W-1:0]     cfg_data        = '0;
	logic                 in_valid        = 1'b0;
	logic                 in_ready;
	logic                 level_first     = 1'b0;
	logic [DUR_W-1:0]     duration_first  = '0;
	logic                 level_second    = 1'b0;
	logic [DUR_W-1:0]     duration_second = '0;
	logic                 last_symbol     = 1'b0;
	logic                 out_valid;
	logic                 out_ready       = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [WORD_W-1:0]    humidity_raw;
	logic [WORD_W-1:0]    temperature_raw;
	logic [BYTE_W-1:0]    checksum_received;

	int          sender_idle_pct    = 0;
	int          receiver_stall_pct = 0;
	int unsigned phase_items;
	int unsigned phase_frames;

	frame_scoreboard sb = new();

	humidity_sensor_pulse_frame_decoder_core #(
		.FRAME_SYMBOLS(FRAME_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.level_first(level_first),
		.duration_first(duration_first),
		.level_second(level_second),
		.duration_second(duration_second),
		.last_symbol(last_symbol),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.humidity_raw(humidity_raw),
		.temperature_raw(temperature_raw),
		.checksum_received(checksum_received)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// both sides sample the values from before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_frame({status, humidity_raw, temperature_raw, checksum_received});
			if (in_valid && in_ready)
				sb.decode_symbol({level_first, duration_first, level_second, duration_second,
					last_symbol});
		end
	end

	function automatic logic [DUR_W-1:0] pick_in(logic [CFG_IDX_W-1:0] lo_reg,
			logic [CFG_IDX_W-1:0] hi_reg);
		logic [DUR_W-1:0] lo;
		logic [DUR_W-1:0] hi;
		lo = sb.windows[lo_reg];
		hi = sb.windows[hi_reg];
		if (lo > hi)
			return DUR_W'($urandom_range(DUR_MAX, 0));
		case ($urandom_range(3))
			0: return lo;
			1: return hi;
			default: return DUR_W'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic logic [DUR_W-1:0] pick_out(logic [CFG_IDX_W-1:0] lo_reg,
			logic [CFG_IDX_W-1:0] hi_reg);
		logic [DUR_W-1:0] lo;
		logic [DUR_W-1:0] hi;
		lo = sb.windows[lo_reg];
		hi = sb.windows[hi_reg];
		if (lo != 0 && (hi == DUR_MAX || $urandom_range(1) == 1))
			return ($urandom_range(3) == 0) ? lo - 1'b1 : DUR_W'($urandom_range(lo - 1, 0));
		if (hi != DUR_MAX)
			return ($urandom_range(3) == 0) ? hi + 1'b1 : DUR_W'($urandom_range(DUR_MAX, hi + 1));
		return DUR_W'($urandom_range(DUR_MAX, 0));
	endfunction

	function automatic pulse_symbol_t symbol_of(logic lv1, logic [DUR_W-1:0] d1, logic lv2,
			logic [DUR_W-1:0] d2, logic last);
		return {lv1, d1, lv2, d2, last};
	endfunction

	function automatic window_set_t make_windows(
			logic [DUR_W-1:0] resp_lo, logic [DUR_W-1:0] resp_hi,
			logic [DUR_W-1:0] lead_lo, logic [DUR_W-1:0] lead_hi,
			logic [DUR_W-1:0] zero_lo, logic [DUR_W-1:0] zero_hi,
			logic [DUR_W-1:0] one_lo, logic [DUR_W-1:0] one_hi);
		window_set_t w;
		w[REG_RESP_MIN] = resp_lo;
		w[REG_RESP_MAX] = resp_hi;
		w[REG_LEAD_MIN] = lead_lo;
		w[REG_LEAD_MAX] = lead_hi;
		w[REG_ZERO_MIN] = zero_lo;
		w[REG_ZERO_MAX] = zero_hi;
		w[REG_ONE_MIN]  = one_lo;
		w[REG_ONE_MAX]  = one_hi;
		return w;
	endfunction

	// min registers sit at even indexes, each max right after its min
	function automatic window_set_t random_windows();
		window_set_t w;
		for (int i = REG_RESP_MIN; i <= REG_ONE_MAX; i += 2) begin
			w[i]     = DUR_W'($urandom_range(DUR_MAX - 400, 0));
			w[i + 1] = w[i] + DUR_W'($urandom_range(400));
		end
		return w;
	endfunction

	task automatic send_symbol(input pulse_symbol_t sym);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		{level_first, duration_first, level_second, duration_second, last_symbol} <= sym;
		do @(posedge clk); while (!in_ready);
		phase_items++;
		if (sym.last_symbol)
			phase_frames++;
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.frames_due() != 0);
	endtask

	// only while idle: a symbol without a result may still be in flight
	task automatic reconfigure(input window_set_t w);
		logic [CFG_IDX_W-1:0] stray;
		logic [DUR_W-1:0]     junk;
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		for (int i = REG_RESP_MIN; i <= REG_ONE_MAX; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= w[i];
			@(posedge clk);
			sb.write_window(CFG_IDX_W'(i), w[i]);
		end
		if ($urandom_range(1) == 1) begin
			stray = CFG_IDX_W'($urandom_range(STRAY_INDEX_HI, STRAY_INDEX_LO));
			junk  = DUR_W'($urandom);
			cfg_index <= stray;
			cfg_data  <= junk;
			@(posedge clk);
			sb.write_window(stray, junk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(input frame_flaw_t flaw);
		logic [FRAME_W-1:0] bits;
		logic [BYTE_W-1:0]  sum;
		pulse_symbol_t      s;
		int                 len;
		int                 spot;
		bits[39:8] = $urandom;
		sum = bits[39:32] + bits[31:24] + bits[23:16] + bits[15:8];
		bits[7:0] = (flaw == FLAW_CHECKSUM) ? sum ^ BYTE_W'($urandom_range(255, 1)) : sum;
		len = FRAME_LEN;
		if (flaw == FLAW_SHORT)
			len = $urandom_range(FRAME_LEN - 1, 1);
		else if (flaw == FLAW_LONG)
			len = $urandom_range(LONG_FRAME_MAX, FRAME_LEN + 1);
		case (flaw)
			FLAW_PREAMBLE: spot = $urandom_range(1);
			FLAW_LEAD:     spot = $urandom_range(LAST_LEAD_SYMBOL, 1);
			FLAW_HIGH:     spot = $urandom_range(LAST_BIT_SYMBOL, FIRST_BIT_SYMBOL);
			default:       spot = -1;
		endcase
		for (int i = 0; i < len; i++) begin
			s.level_first     = (i < FIRST_BIT_SYMBOL) ? 1'b1 : 1'($urandom_range(1));
			s.duration_first  = DUR_W'($urandom);
			s.level_second    = (i < FRAME_LEN) ? 1'b0 : 1'($urandom_range(1));
			s.duration_second = DUR_W'($urandom);
			s.last_symbol     = (i == len - 1);
			if (i == 0)
				s.duration_second = pick_in(REG_RESP_MIN, REG_RESP_MAX);
			if (i == 1)
				s.duration_first = pick_in(REG_RESP_MIN, REG_RESP_MAX);
			if (i >= FIRST_BIT_SYMBOL && i < FRAME_LEN)
				s.duration_first = bits[FRAME_LEN - 1 - i] ? pick_in(REG_ONE_MIN, REG_ONE_MAX) :
					pick_in(REG_ZERO_MIN, REG_ZERO_MAX);
			if (i >= 1 && i <= LAST_LEAD_SYMBOL)
				s.duration_second = pick_in(REG_LEAD_MIN, REG_LEAD_MAX);
			if (i == spot) begin
				case (flaw)
					FLAW_PREAMBLE: begin
						case ($urandom_range(2))
							0: s.level_first = 1'b0;
							1: if (i == 0) s.level_second = 1'b1; else s.level_first = 1'b0;
							default: begin
								if (i == 0)
									s.duration_second = pick_out(REG_RESP_MIN, REG_RESP_MAX);
								else
									s.duration_first = pick_out(REG_RESP_MIN, REG_RESP_MAX);
							end
						endcase
					end
					FLAW_LEAD: begin
						if ($urandom_range(1) == 1)
							s.level_second = 1'b1;
						else
							s.duration_second = pick_out(REG_LEAD_MIN, REG_LEAD_MAX);
					end
					default: begin
						s.duration_first = pick_out(REG_ZERO_MIN, REG_ZERO_MAX);
						if (sb.fits(s.duration_first, REG_ONE_MIN, REG_ONE_MAX))
							s.duration_first = pick_out(REG_ONE_MIN, REG_ONE_MAX);
					end
				endcase
			end
			send_symbol(s);
		end
	endtask

	task automatic send_noise();
		pulse_symbol_t s;
		int            n;
		n = $urandom_range(3, 1);
		for (int k = 0; k < n; k++) begin
			s.level_first     = 1'($urandom_range(1));
			s.duration_first  = DUR_W'($urandom);
			s.level_second    = 1'($urandom_range(1));
			s.duration_second = DUR_W'($urandom);
			s.last_symbol     = (k == n - 1) || ($urandom_range(3) == 0);
			send_symbol(s);
		end
	endtask

	task automatic send_random_capture();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 55)
			send_frame(FLAW_NONE);
		else if (pick < 63)
			send_frame(FLAW_CHECKSUM);
		else if (pick < 70)
			send_frame(FLAW_PREAMBLE);
		else if (pick < 77)
			send_frame(FLAW_LEAD);
		else if (pick < 84)
			send_frame(FLAW_HIGH);
		else if (pick < 90)
			send_frame(FLAW_SHORT);
		else if (pick < 94)
			send_frame(FLAW_LONG);
		else
			send_noise();
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct);
		bit paused;
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		phase_items  = 0;
		phase_frames = 0;
		paused = 1'b0;
		while (phase_items < PHASE_ITEMS || phase_frames < PHASE_FRAMES) begin
			send_random_capture();
			// hold the sender off once until the result side has drained
			if (!paused && phase_items >= PHASE_ITEMS / 2) begin
				wait_results_done();
				paused = 1'b1;
			end
		end
	endtask

	task automatic send_directed();
		send_symbol(symbol_of(1'b0, '0, 1'b0, '0, 1'b1));
		send_symbol(symbol_of(1'b1, DUR_MAX, 1'b1, DUR_MAX, 1'b1));
		// good preamble at the window edges, capture cut short
		send_symbol(symbol_of(1'b1, '0, 1'b0, RESP_MIN_RST, 1'b0));
		send_symbol(symbol_of(1'b1, RESP_MAX_RST, 1'b0, LEAD_MIN_RST, 1'b1));
		send_symbol(symbol_of(1'b0, DUR_MAX, 1'b0, RESP_MAX_RST, 1'b0));
		send_symbol(symbol_of(1'b1, RESP_MIN_RST, 1'b0, LEAD_MAX_RST, 1'b1));
		send_symbol(symbol_of(1'b1, 15'd5, 1'b0, RESP_MAX_RST + 1'b1, 1'b1));
		send_symbol(symbol_of(1'b1, 15'd5, 1'b0, RESP_MIN_RST - 1'b1, 1'b1));
		send_symbol(symbol_of(1'b1, '0, 1'b0, 15'd80, 1'b0));
		send_symbol(symbol_of(1'b0, 15'd80, 1'b0, 15'd50, 1'b0));
		send_symbol(symbol_of(1'b1, ZERO_MAX_RST, 1'b1, LEAD_MAX_RST, 1'b1));
		send_symbol(symbol_of(1'b1, '0, 1'b0, 15'd80, 1'b0));
		send_symbol(symbol_of(1'b1, RESP_MIN_RST - 1'b1, 1'b0, LEAD_MAX_RST + 1'b1, 1'b1));
	endtask

	initial begin
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		run_phase(0, 0);
		reconfigure(make_windows(15'd70, 15'd90, 15'd40, 15'd60, 15'd15, 15'd35, 15'd60, 15'd80));
		run_phase(45, 0);
		reconfigure(make_windows('0, '0, '0, '0, '0, '0, '0, '0));
		run_phase(0, 45);
		reconfigure(make_windows('0, DUR_MAX, '0, DUR_MAX, '0, DUR_MAX, '0, DUR_MAX));
		run_phase(23, 23);
		// every window empty
		reconfigure(make_windows(DUR_MAX, '0, DUR_MAX, '0, DUR_MAX, '0, DUR_MAX, '0));
		run_phase(0, 0);
		reconfigure(make_windows(DUR_MAX - 700, DUR_MAX, DUR_MAX - 7, DUR_MAX,
			DUR_MAX, DUR_MAX, DUR_MAX - 60, DUR_MAX));
		run_phase(45, 0);
		// bit windows overlap, zero wins in the shared range
		reconfigure(make_windows(RESP_MIN_RST, RESP_MAX_RST, LEAD_MIN_RST, LEAD_MAX_RST,
			15'd20, 15'd60, 15'd40, 15'd90));
		run_phase(0, 45);
		reconfigure(random_windows());
		run_phase(23, 23);

		in_valid <= 1'b0;
		n = 0;
		while (sb.frames_due() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.flush_leftovers();
		if (sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> humidity_sensor_pulse_frame_decoder_core.f
sv/hspf_pkg.sv
sv/hspf_cfg_regs.sv
sv/hspf_symbol_class.sv
sv/hspf_frame_acc.sv
sv/humidity_sensor_pulse_frame_decoder_core.sv
sv/hspf_checker.sv
bench/hspf_frame_check_pkg.sv
bench/humidity_sensor_pulse_frame_decoder_core_test.sv
